>>> sv/bscp_pkg.sv
// shared types and constants of the bevel shadow colour pair block
package bscp_pkg;

  localparam int unsigned FIELD_W = 16;
  localparam int unsigned COEF_W  = 16;

  // brightness bands
  localparam logic [1:0] BAND_DARK  = 2'd0;
  localparam logic [1:0] BAND_MID   = 2'd1;
  localparam logic [1:0] BAND_LIGHT = 2'd2;

  // register index codes
  localparam logic REG_DARK  = 1'b0;
  localparam logic REG_LIGHT = 1'b1;

  localparam logic [FIELD_W-1:0] DARK_RESET  = 16'd9830;
  localparam logic [FIELD_W-1:0] LIGHT_RESET = 16'd49151;

  // unsigned q0.16 coefficients
  localparam logic [COEF_W-1:0] K_R   = 16'd19661;
  localparam logic [COEF_W-1:0] K_G   = 16'd38666;
  localparam logic [COEF_W-1:0] K_B   = 16'd7209;
  localparam logic [COEF_W-1:0] K_02  = 16'd13107;
  localparam logic [COEF_W-1:0] K_05  = 16'd32768;
  localparam logic [COEF_W-1:0] K_095 = 16'd62259;
  localparam logic [COEF_W-1:0] K_060 = 16'd39322;
  localparam logic [COEF_W-1:0] K_025 = 16'd16384;
  localparam logic [COEF_W-1:0] K_040 = 16'd26214;
  localparam logic [COEF_W-1:0] K_030 = 16'd19661;

  typedef struct packed {
    logic [FIELD_W-1:0] red;
    logic [FIELD_W-1:0] green;
    logic [FIELD_W-1:0] blue;
  } color_t;

  typedef struct packed {
    logic [FIELD_W-1:0] top_red;
    logic [FIELD_W-1:0] top_green;
    logic [FIELD_W-1:0] top_blue;
    logic [FIELD_W-1:0] bottom_red;
    logic [FIELD_W-1:0] bottom_green;
    logic [FIELD_W-1:0] bottom_blue;
    logic [1:0]         band;
  } shadow_t;

endpackage

>>> sv/bscp_stream_if.sv
// valid/ready stream channel carrying one beat of payload
interface bscp_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/bevel_shadow_color_pair_core.sv
// bevel shadow colour pair: top and bottom shadow colours from one base colour
//
// color_i takes one rgb beat per cycle while not stalled; shadow_o returns the top
// shadow colour, the bottom shadow colour and the brightness band for it, in order.
// the apb port holds dark_limit (0x0) and light_limit (0x4); write them only
// while no beat is in flight. pready is always high and reads return the value.
// a beat accepted on color_i leaves on shadow_o through a ten-stage pipeline (mean,
// luma, brightness, two constant divisions by the channel maximum, the per-channel
// products, clamp).
// throughput: one beat per cycle while shadow_o is ready, set by the single-beat stages.
// every stage has its own valid bit and loads when empty or when its successor
// moves, so a stall on shadow_o fills the bubbles first and color_i drops ready
// only when all ten stages hold a beat. nothing is lost or repeated.
// reset (rst_ni low, asynchronous) empties the pipeline and returns both limits
// to 9830 and 49151.
module bevel_shadow_color_pair_core import bscp_pkg::*; #(
  parameter int unsigned CHANNEL_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  bscp_stream_if.sink         color_i,
  bscp_stream_if.source       shadow_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned N          = CHANNEL_BITS;
  localparam logic [N-1:0] CMAX      = {N{1'b1}};
  localparam int unsigned SUM_W      = N + 2;
  localparam int unsigned DIV3_SHIFT = N + 2;
  localparam logic [N:0]  DIV3_RECIP = (N+1)'((64'd1 << DIV3_SHIFT) / 3);
  localparam int unsigned MP_W       = 2 * N + 3;
  localparam int unsigned ACC_W      = N + 16;
  localparam int unsigned ACC3_W     = N + 18;
  localparam int unsigned BS_W       = N + 19;
  localparam int unsigned P_W        = N + 15;
  localparam int unsigned DIV_SHIFT  = N + 15;
  localparam logic [16:0] DIV_RECIP  = 17'((64'd1 << DIV_SHIFT) / ((64'd1 << N) - 64'd1));
  localparam int unsigned EST_W      = P_W + 17;
  localparam int unsigned Q_W        = 15;
  localparam int unsigned RW         = P_W + 1;
  localparam logic [COEF_W:0] FT_MAX = (COEF_W+1)'(K_040) + (COEF_W+1)'(K_030);
  localparam logic [COEF_W-1:0] FB_MIN = K_060 - K_025;

  // configuration
  logic [FIELD_W-1:0] dark_q, light_q;
  logic               cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = {16'b0, (paddr[2] == REG_LIGHT) ? light_q : dark_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dark_q  <= DARK_RESET;
      light_q <= LIGHT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_LIGHT) begin
        light_q <= pwdata[FIELD_W-1:0];
      end else begin
        dark_q <= pwdata[FIELD_W-1:0];
      end
    end
  end

  // stage valid bits and advance chain
  logic [10:1] v_q;
  logic [10:1] v_in;
  logic [11:1] adv;

  assign v_in = {v_q[9:1], color_i.valid};

  always_comb begin
    adv[11] = shadow_o.ready;
    for (int k = 10; k >= 1; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign color_i.ready  = adv[1];
  assign shadow_o.valid = v_q[10];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 1; k <= 10; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  // payload registers
  logic [N-1:0]        ch_q [1:9][3];
  logic [1:0]          band_q [5:9];
  logic [SUM_W-1:0]    sum2_q, sum3_q;
  logic [ACC_W-1:0]    prod2_q [3];
  logic [ACC_W-1:0]    acc3_q;
  logic [MP_W-1:0]     mprod3_q;
  logic [N-1:0]        mean4_q;
  logic [ACC3_W-1:0]   acc4_q;
  logic [N-1:0]        bright5_q;
  logic [P_W-1:0]      p25_6_q, p30_6_q, p25_7_q, p30_7_q;
  logic [Q_W-1:0]      e25_7_q, e30_7_q;
  logic [COEF_W-1:0]   ft8_q, fb8_q;
  logic [N-1:0]        tp9_q [3];
  logic [N-1:0]        bp9_q [3];
  shadow_t             out_q;

  // combinational stage logic
  logic [ACC_W-1:0]    acc_d;
  logic [MP_W-1:0]     mprod_d;
  logic [N-1:0]        e3;
  logic [SUM_W-1:0]    rem3;
  logic [N-1:0]        mean_d;
  logic [BS_W-1:0]     bsum;
  logic [N:0]          braw;
  logic [N-1:0]        bright_d;
  logic [1:0]          band_d;
  logic [EST_W-1:0]    est25, est30;
  logic [RW-1:0]       rem25, rem30;
  logic [Q_W-1:0]      q25, q30;
  logic [N-1:0]        ta [3];
  logic [N-1:0]        ba [3];
  logic [COEF_W-1:0]   tk, bk;
  logic [N+COEF_W-1:0] tprod [3];
  logic [N+COEF_W-1:0] bprod [3];
  logic [N:0]          tsum [3];
  logic [N:0]          bsum_c [3];
  logic [N-1:0]        tres [3];
  logic [N-1:0]        bres [3];

  always_comb begin
    acc_d   = prod2_q[0] + prod2_q[1] + prod2_q[2];
    mprod_d = MP_W'(sum2_q) * MP_W'(DIV3_RECIP);

    // mean: reciprocal estimate, then one correction step
    e3     = mprod3_q[DIV3_SHIFT +: N];
    rem3   = sum3_q - SUM_W'(e3) - (SUM_W'(e3) << 1);
    mean_d = e3 + N'(rem3 >= SUM_W'(3));

    bsum     = (BS_W'(mean4_q) << 16) + BS_W'(acc4_q);
    braw     = bsum[18 +: N+1];
    bright_d = (braw > (N+1)'(CMAX)) ? CMAX : braw[N-1:0];
    if (FIELD_W'(bright_d) <= dark_q) begin
      band_d = BAND_DARK;
    end else if (FIELD_W'(bright_d) > light_q) begin
      band_d = BAND_LIGHT;
    end else begin
      band_d = BAND_MID;
    end

    // division by the channel maximum
    est25 = EST_W'(p25_6_q) * EST_W'(DIV_RECIP);
    est30 = EST_W'(p30_6_q) * EST_W'(DIV_RECIP);
    rem25 = RW'(p25_7_q) + RW'(e25_7_q) - (RW'(e25_7_q) << N);
    rem30 = RW'(p30_7_q) + RW'(e30_7_q) - (RW'(e30_7_q) << N);
    q25   = e25_7_q + Q_W'(rem25 >= RW'(CMAX));
    q30   = e30_7_q + Q_W'(rem30 >= RW'(CMAX));

    // coefficient selection per band
    case (band_q[8])
      BAND_DARK: begin
        tk = K_05;
        bk = K_02;
      end
      BAND_LIGHT: begin
        tk = K_095;
        bk = K_02;
      end
      default: begin
        tk = ft8_q;
        bk = fb8_q;
      end
    endcase

    for (int i = 0; i < 3; i++) begin
      ta[i]    = (band_q[8] == BAND_LIGHT) ? ch_q[8][i] : CMAX - ch_q[8][i];
      ba[i]    = (band_q[8] == BAND_DARK) ? CMAX - ch_q[8][i] : ch_q[8][i];
      tprod[i] = (N+COEF_W)'(ta[i]) * (N+COEF_W)'(tk);
      bprod[i] = (N+COEF_W)'(ba[i]) * (N+COEF_W)'(bk);

      case (band_q[9])
        BAND_DARK: begin
          tsum[i]   = (N+1)'(ch_q[9][i]) + (N+1)'(tp9_q[i]);
          bsum_c[i] = (N+1)'(ch_q[9][i]) + (N+1)'(bp9_q[i]);
        end
        BAND_LIGHT: begin
          tsum[i]   = (N+1)'(tp9_q[i]);
          bsum_c[i] = (N+1)'(bp9_q[i]);
        end
        default: begin
          tsum[i]   = (N+1)'(ch_q[9][i]) + (N+1)'(tp9_q[i]);
          bsum_c[i] = (N+1)'(ch_q[9][i]) - (N+1)'(bp9_q[i]);
        end
      endcase
      tres[i] = (tsum[i] > (N+1)'(CMAX)) ? CMAX : tsum[i][N-1:0];
      bres[i] = (bsum_c[i] > (N+1)'(CMAX)) ? CMAX : bsum_c[i][N-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      ch_q[1][0] <= color_i.data.red[N-1:0];
      ch_q[1][1] <= color_i.data.green[N-1:0];
      ch_q[1][2] <= color_i.data.blue[N-1:0];
    end
    for (int k = 2; k <= 9; k++) begin
      if (adv[k]) begin
        ch_q[k] <= ch_q[k-1];
      end
    end
    if (adv[2]) begin
      sum2_q     <= SUM_W'(ch_q[1][0]) + SUM_W'(ch_q[1][1]) + SUM_W'(ch_q[1][2]);
      prod2_q[0] <= ACC_W'(ch_q[1][0]) * ACC_W'(K_R);
      prod2_q[1] <= ACC_W'(ch_q[1][1]) * ACC_W'(K_G);
      prod2_q[2] <= ACC_W'(ch_q[1][2]) * ACC_W'(K_B);
    end
    if (adv[3]) begin
      sum3_q   <= sum2_q;
      acc3_q   <= acc_d;
      mprod3_q <= mprod_d;
    end
    if (adv[4]) begin
      mean4_q <= mean_d;
      acc4_q  <= ACC3_W'(acc3_q) + (ACC3_W'(acc3_q) << 1);
    end
    if (adv[5]) begin
      bright5_q <= bright_d;
      band_q[5] <= band_d;
    end
    for (int k = 6; k <= 9; k++) begin
      if (adv[k]) begin
        band_q[k] <= band_q[k-1];
      end
    end
    if (adv[6]) begin
      p25_6_q <= P_W'(bright5_q) * P_W'(K_025);
      p30_6_q <= P_W'(bright5_q) * P_W'(K_030);
    end
    if (adv[7]) begin
      p25_7_q <= p25_6_q;
      p30_7_q <= p30_6_q;
      e25_7_q <= est25[DIV_SHIFT +: Q_W];
      e30_7_q <= est30[DIV_SHIFT +: Q_W];
    end
    if (adv[8]) begin
      ft8_q <= K_040 + COEF_W'(q30);
      fb8_q <= K_060 - COEF_W'(q25);
    end
    if (adv[9]) begin
      for (int i = 0; i < 3; i++) begin
        tp9_q[i] <= tprod[i][COEF_W +: N];
        bp9_q[i] <= bprod[i][COEF_W +: N];
      end
    end
    if (adv[10]) begin
      out_q.top_red      <= FIELD_W'(tres[0]);
      out_q.top_green    <= FIELD_W'(tres[1]);
      out_q.top_blue     <= FIELD_W'(tres[2]);
      out_q.bottom_red   <= FIELD_W'(bres[0]);
      out_q.bottom_green <= FIELD_W'(bres[1]);
      out_q.bottom_blue  <= FIELD_W'(bres[2]);
      out_q.band         <= band_q[9];
    end
  end

  assign shadow_o.data = out_q;

  // checks
  a_accept_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    color_i.valid && color_i.ready |=> v_q[1])
    else $error("accepted beat did not enter the first stage");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !color_i.ready |-> (&v_q))
    else $error("input stalled with a bubble in the pipeline");

  a_factor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[8] |-> ((COEF_W+1)'(ft8_q) <= FT_MAX) && (fb8_q >= FB_MIN))
    else $error("middle band factor out of range");

  a_top_not_below_bottom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shadow_o.valid |-> (shadow_o.data.top_red >= shadow_o.data.bottom_red) &&
                       (shadow_o.data.top_green >= shadow_o.data.bottom_green) &&
                       (shadow_o.data.top_blue >= shadow_o.data.bottom_blue))
    else $error("top shadow darker than bottom shadow");

endmodule

>>> tb/tb.sv
// self-checking testbench for bevel_shadow_color_pair_core: predicted shadow pairs vs dut output
`timescale 1ns / 1ps

module tb;
  import bscp_pkg::*;

  localparam int unsigned PIPE_DEPTH     = 10;
  localparam int unsigned JAM_CYCLES     = 80;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned IDLE_PERCENT   = 21;
  localparam longint unsigned CMAX       = 65535;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bscp_stream_if #(.T(color_t))  color_if ();
  bscp_stream_if #(.T(shadow_t)) shadow_if ();

  bevel_shadow_color_pair_core dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .color_i  (color_if.sink),
    .shadow_o (shadow_if.source),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #10 clk = ~clk;

  logic [FIELD_W-1:0] dark_lim  = DARK_RESET;
  logic [FIELD_W-1:0] light_lim = LIGHT_RESET;
  shadow_t            pending_shadows[$];
  int unsigned        mismatches   = 0;
  int unsigned        stall_cycles = 0;
  int unsigned        jam_asked    = 0;
  int unsigned        jam_served   = 0;
  bit                 no_idle      = 1'b0;

  function automatic longint unsigned sat16(longint unsigned v);
    return (v > CMAX) ? CMAX : v;
  endfunction

  function automatic shadow_t shade_pair(color_t c, logic [FIELD_W-1:0] dk,
                                         logic [FIELD_W-1:0] lt);
    longint unsigned ch[3];
    longint unsigned tops[3];
    longint unsigned bots[3];
    longint unsigned mean, luma, bright, ft, fb;
    shadow_t s;
    ch[0] = c.red;
    ch[1] = c.green;
    ch[2] = c.blue;
    mean = (ch[0] + ch[1] + ch[2]) / 3;
    luma = 64'(K_R) * ch[0] + 64'(K_G) * ch[1] + 64'(K_B) * ch[2];
    bright = sat16((mean * 65536 + 3 * luma) >> 18);
    if (bright <= 64'(dk)) begin
      s.band = BAND_DARK;
      for (int i = 0; i < 3; i++) begin
        tops[i] = sat16(ch[i] + (((CMAX - ch[i]) * 64'(K_05)) >> 16));
        bots[i] = sat16(ch[i] + (((CMAX - ch[i]) * 64'(K_02)) >> 16));
      end
    end else if (bright > 64'(lt)) begin
      s.band = BAND_LIGHT;
      for (int i = 0; i < 3; i++) begin
        tops[i] = sat16((ch[i] * 64'(K_095)) >> 16);
        bots[i] = sat16((ch[i] * 64'(K_02)) >> 16);
      end
    end else begin
      s.band = BAND_MID;
      fb = 64'(K_060) - (64'(K_025) * bright) / CMAX;
      ft = 64'(K_040) + (64'(K_030) * bright) / CMAX;
      for (int i = 0; i < 3; i++) begin
        tops[i] = sat16(ch[i] + (((CMAX - ch[i]) * ft) >> 16));
        bots[i] = sat16(ch[i] - ((ch[i] * fb) >> 16));
      end
    end
    s.top_red      = 16'(tops[0]);
    s.top_green    = 16'(tops[1]);
    s.top_blue     = 16'(tops[2]);
    s.bottom_red   = 16'(bots[0]);
    s.bottom_green = 16'(bots[1]);
    s.bottom_blue  = 16'(bots[2]);
    return s;
  endfunction

  function automatic logic [FIELD_W-1:0] near(logic [FIELD_W-1:0] base, int unsigned span);
    int v;
    v = int'(base) + int'($urandom_range(2 * span)) - int'(span);
    if (v < 0) v = 0;
    if (v > int'(CMAX)) v = int'(CMAX);
    return FIELD_W'(v);
  endfunction

  function automatic logic [FIELD_W-1:0] edge_channel();
    case ($urandom_range(4))
      0: return '0;
      1: return '1;
      2: return 16'd1;
      3: return 16'hfffe;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  function automatic color_t rand_color();
    color_t c;
    logic [FIELD_W-1:0] base;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) begin
      c.red   = 16'($urandom_range(65535));
      c.green = 16'($urandom_range(65535));
      c.blue  = 16'($urandom_range(65535));
    end else if (pick < 75) begin
      base    = near($urandom_range(1) ? dark_lim : light_lim, 3);
      c.red   = near(base, 2);
      c.green = near(base, 2);
      c.blue  = near(base, 2);
    end else if (pick < 90) begin
      c.red   = edge_channel();
      c.green = edge_channel();
      c.blue  = edge_channel();
    end else begin
      c.red   = 16'($urandom_range(65535));
      c.green = c.red;
      c.blue  = c.red;
    end
    return c;
  endfunction

  function automatic color_t gray(longint unsigned v);
    color_t c;
    c.red   = 16'(sat16(v));
    c.green = c.red;
    c.blue  = c.red;
    return c;
  endfunction

  task automatic note_fault(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) note_fault($sformatf("%s expected %0d, got %0d", name, want, got));
  endtask

  // each beat on the output sampled at the falling edge before it is taken
  always @(negedge clk) begin
    shadow_t want;
    if (rst_n && shadow_if.valid && shadow_if.ready) begin
      if (pending_shadows.size() == 0) begin
        note_fault("output beat with nothing expected");
      end else begin
        want = pending_shadows.pop_front();
        check_field("top_red", want.top_red, shadow_if.data.top_red);
        check_field("top_green", want.top_green, shadow_if.data.top_green);
        check_field("top_blue", want.top_blue, shadow_if.data.top_blue);
        check_field("bottom_red", want.bottom_red, shadow_if.data.bottom_red);
        check_field("bottom_green", want.bottom_green, shadow_if.data.bottom_green);
        check_field("bottom_blue", want.bottom_blue, shadow_if.data.bottom_blue);
        check_field("band", want.band, shadow_if.data.band);
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if ((color_if.valid && color_if.ready) || (shadow_if.valid && shadow_if.ready) || psel)
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    shadow_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (jam_asked != jam_served) begin
        shadow_if.ready <= 1'b0;
        repeat (JAM_CYCLES) @(posedge clk);
        jam_served++;
      end else begin
        shadow_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  task automatic send_color(input color_t c);
    while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
      color_if.valid <= 1'b0;
      color_if.data  <= rand_color();
      @(posedge clk);
    end
    color_if.valid <= 1'b1;
    color_if.data  <= c;
    @(negedge clk);
    while (!color_if.ready) @(negedge clk);
    @(posedge clk);
    pending_shadows.push_back(shade_pair(c, dark_lim, light_lim));
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_color(rand_color());
  endtask

  task automatic wait_idle();
    color_if.valid <= 1'b0;
    while (pending_shadows.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic write_limit(input logic idx, input logic [FIELD_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom_range(65535)), v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_DARK) dark_lim = v;
    else light_lim = v;
    @(posedge clk);
  endtask

  task automatic read_limit(input logic idx, input logic [FIELD_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    check_field(idx == REG_DARK ? "dark_limit read" : "light_limit read", want, prdata[15:0]);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_limits(input logic [FIELD_W-1:0] dk, input logic [FIELD_W-1:0] lt);
    wait_idle();
    write_limit(REG_DARK, dk);
    write_limit(REG_LIGHT, lt);
    read_limit(REG_DARK, dk);
    read_limit(REG_LIGHT, lt);
  endtask

  task automatic test_reset_values();
    read_limit(REG_DARK, DARK_RESET);
    read_limit(REG_LIGHT, LIGHT_RESET);
    send_random(3);
    wait_idle();
  endtask

  // grey of level v has brightness exactly v, so greys probe the band edges
  task automatic test_directed_colors();
    send_color(gray(0));
    send_color(gray(CMAX));
    send_color(gray(9830));
    send_color(gray(9831));
    send_color(gray(49151));
    send_color(gray(49152));
    send_color(gray(32768));
    send_color(gray(1));
    send_color(gray(65534));
    send_color(color_t'{red: 16'hffff, green: 16'h0000, blue: 16'h0000});
    send_color(color_t'{red: 16'h0000, green: 16'hffff, blue: 16'h0000});
    send_color(color_t'{red: 16'h0000, green: 16'h0000, blue: 16'hffff});
    send_color(color_t'{red: 16'hffff, green: 16'h0000, blue: 16'hffff});
    send_color(color_t'{red: 16'haaaa, green: 16'h5555, blue: 16'haaaa});
    send_color(color_t'{red: 16'h5555, green: 16'haaaa, blue: 16'h5555});
    send_color(color_t'{red: 16'hffff, green: 16'hffff, blue: 16'h0000});
    wait_idle();
  endtask

  task automatic test_limit_settings();
    logic [FIELD_W-1:0] dks[8];
    logic [FIELD_W-1:0] lts[8];
    dks = '{16'd0, 16'd0, 16'hffff, 16'hffff, 16'd40000, 16'd1000,
            16'($urandom_range(65535)), 16'($urandom_range(65535))};
    lts = '{16'hffff, 16'd0, 16'hffff, 16'd0, 16'd20000, 16'd60000,
            16'($urandom_range(65535)), 16'($urandom_range(65535))};
    for (int i = 0; i < 8; i++) begin
      set_limits(dks[i], lts[i]);
      send_color(gray(dark_lim));
      send_color(gray(64'(dark_lim) + 1));
      send_color(gray(light_lim));
      send_color(gray(64'(light_lim) + 1));
      send_random(18);
    end
    wait_idle();
  endtask

  task automatic test_backpressure();
    set_limits(DARK_RESET, LIGHT_RESET);
    no_idle = 1'b1;
    jam_asked++;
    send_random(60);
    no_idle = 1'b0;
    wait_idle();
  endtask

  task automatic test_random_stream();
    logic [FIELD_W-1:0] a, b;
    no_idle = 1'b1;
    send_random(120);
    no_idle = 1'b0;
    send_random(200);
    repeat (2) begin
      a = 16'($urandom_range(65535));
      b = 16'($urandom_range(65535));
      if (a > b) set_limits(b, a);
      else set_limits(a, b);
      send_random(30);
    end
    set_limits(DARK_RESET, LIGHT_RESET);
  endtask

  initial begin
    rst_n          <= 1'b0;
    color_if.valid <= 1'b0;
    color_if.data  <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_directed_colors();
    test_limit_settings();
    test_backpressure();
    test_random_stream();
    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_shadows.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> bevel_shadow_color_pair_core.f
sv/bscp_pkg.sv
sv/bscp_stream_if.sv
sv/bevel_shadow_color_pair_core.sv
tb/tb.sv
